### sv/blvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blvr_pkg: shared definitions for the bounded list
// Operation and status codes, field widths and the structs that travel
// between the list control and the storage cells.
// ----------------------------------------------------------------------------
package blvr_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int MODE_W    = 3;
  localparam int STAT_W    = 2;
  localparam int COUNT_W   = 5;

  // Word returned by a read of an empty list.
  localparam logic signed [WORD_W-1:0] EMPTY_READ = -32'sd999;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND    = 3'd0,
    MODE_RMV_VALUE = 3'd1,
    MODE_RMV_HEAD  = 3'd2,
    MODE_RMV_TAIL  = 3'd3,
    MODE_RD_HEAD   = 3'd4,
    MODE_RD_TAIL   = 3'd5
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Broadcast from the control to every cell.
  typedef struct packed {
    logic              append;
    logic              scan;
    logic              shift;
    logic [WORD_W-1:0] value;
  } cell_ctl_t;

  // Handed from each cell to the next one toward the tail.
  typedef struct packed {
    logic              seen;
    logic [WORD_W-1:0] tail;
  } link_t;

endpackage

### sv/blvr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blvr_cell: one storage position of the bounded list
// Holds one word, compares it against the broadcast value, passes the
// first-match flag and the tail word down the chain, and takes its
// neighbor's word when the list closes a gap.
// ----------------------------------------------------------------------------
module blvr_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                        clk,
  input  blvr_pkg::cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]            count,
  input  logic [blvr_pkg::WORD_W-1:0] next_data,
  input  blvr_pkg::link_t             link_in,
  output blvr_pkg::link_t             link_out,
  output logic [blvr_pkg::WORD_W-1:0] data
);

  logic [blvr_pkg::WORD_W-1:0] data_r;
  logic [blvr_pkg::WORD_W-1:0] data_nxt;
  logic                        occupied;
  logic                        is_tail;
  logic                        is_slot;
  logic                        match;

  assign occupied = CNT_W'(IDX) < count;
  assign is_tail  = CNT_W'(IDX + 1) == count;
  assign is_slot  = CNT_W'(IDX) == count;
  assign match    = ctl.scan && occupied && (data_r == ctl.value);

  // Once a match is seen, this cell and every later one shift up by one.
  assign link_out.seen = link_in.seen | match;
  assign link_out.tail = link_in.tail | (is_tail ? data_r : '0);

  always_comb begin
    data_nxt = data_r;
    if (ctl.shift && link_out.seen) begin
      data_nxt = next_data;
    end else if (ctl.append && is_slot) begin
      data_nxt = ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

### sv/bounded_list_with_value_removal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_with_value_removal: ordered list of up to DEPTH signed words
// Every item carries one operation (append, remove by value, remove head,
// remove tail, read head, read tail) and gives exactly one result item with
// a status, the word read and the entry count after the operation.
//
// Channels: in_* carries mode and value, out_* carries status, data and
// count. Both use valid and stall; an item moves at an edge with valid high
// and stall low.
// The result is registered and presented in the cycle after the item is accepted.
// Throughput: one item per cycle unless the output stalls. Each position is a
// cell in a chain; the compare, first-match flag and gap-closing shift run across
// the whole chain in the accept cycle, so chain length sets the critical path.
// Reset: the entry count and the output valid clear; stored words are
// undefined until written, but only positions below the count are read.
// Stall: a waiting result holds its payload; a new item is taken in the same
// cycle the waiting result leaves, and is held off while it stays stalled.
// ----------------------------------------------------------------------------
module bounded_list_with_value_removal #(
  parameter int DEPTH = blvr_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [blvr_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [blvr_pkg::WORD_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [blvr_pkg::STAT_W-1:0]        out_status,
  output logic signed [blvr_pkg::WORD_W-1:0] out_data,
  output logic [blvr_pkg::COUNT_W-1:0]       out_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                        accept;
  logic                        empty;
  logic                        full;
  logic                        found;
  blvr_pkg::cell_ctl_t         ctl;
  blvr_pkg::link_t             link [DEPTH:0];
  logic [blvr_pkg::WORD_W-1:0] cell_data [DEPTH-1:0];

  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  blvr_pkg::status_t           status_r, status_nxt;
  logic [blvr_pkg::WORD_W-1:0] data_r, data_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign empty    = count_r == '0;
  assign full     = count_r == CNT_W'(DEPTH);
  assign found    = link[DEPTH].seen;

  // Remove head starts the chain already matched, so every cell shifts.
  assign link[0].seen = (in_mode == blvr_pkg::MODE_RMV_HEAD);
  assign link[0].tail = '0;

  assign ctl.value  = in_value;
  assign ctl.scan   = (in_mode == blvr_pkg::MODE_RMV_VALUE);
  assign ctl.append = accept && (in_mode == blvr_pkg::MODE_APPEND) && !full;
  assign ctl.shift  = accept && !empty &&
                      (((in_mode == blvr_pkg::MODE_RMV_VALUE) && found) ||
                       (in_mode == blvr_pkg::MODE_RMV_HEAD));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [blvr_pkg::WORD_W-1:0] next_word;
    if (i == DEPTH - 1) begin : g_last
      assign next_word = cell_data[i];
    end else begin : g_mid
      assign next_word = cell_data[i+1];
    end
    blvr_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .next_data (next_word),
      .link_in   (link[i]),
      .link_out  (link[i+1]),
      .data      (cell_data[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = blvr_pkg::ST_DONE;
    data_nxt   = '0;
    case (in_mode)
      blvr_pkg::MODE_APPEND: begin
        if (full) begin
          status_nxt = blvr_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      blvr_pkg::MODE_RMV_VALUE: begin
        if (empty) begin
          status_nxt = blvr_pkg::ST_EMPTY;
        end else if (found) begin
          count_nxt = count_r - 1'b1;
        end else begin
          status_nxt = blvr_pkg::ST_NOT_FOUND;
        end
      end
      blvr_pkg::MODE_RMV_HEAD, blvr_pkg::MODE_RMV_TAIL: begin
        if (empty) begin
          status_nxt = blvr_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      blvr_pkg::MODE_RD_HEAD: begin
        if (empty) begin
          status_nxt = blvr_pkg::ST_EMPTY;
          data_nxt   = blvr_pkg::EMPTY_READ;
        end else begin
          data_nxt = cell_data[0];
        end
      end
      blvr_pkg::MODE_RD_TAIL: begin
        if (empty) begin
          status_nxt = blvr_pkg::ST_EMPTY;
          data_nxt   = blvr_pkg::EMPTY_READ;
        end else begin
          data_nxt = link[DEPTH].tail;
        end
      end
      default: begin
        // Unused modes leave the list alone and report done.
        count_nxt = count_r;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
    end
  end

  // The count register is mirrored in the result through count_q.
  logic [CNT_W-1:0] count_q;
  assign count_q = count_r;

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_data   = data_r;
  assign out_count  = blvr_pkg::COUNT_W'(count_q);

endmodule

### sv/blvr_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blvr_chk: port-level checks for the bounded list
// Watches the handshakes and result fields of the top level over time.
// ----------------------------------------------------------------------------
module blvr_chk #(
  parameter int DEPTH = blvr_pkg::DEPTH_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [blvr_pkg::STAT_W-1:0]        out_status,
  input logic signed [blvr_pkg::WORD_W-1:0] out_data,
  input logic [blvr_pkg::COUNT_W-1:0]       out_count
);

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Every accepted item shows up as a result on the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item produced no result");

  // An empty status only comes from a list that holds nothing.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == blvr_pkg::ST_EMPTY) |-> out_count == '0)
    else $error("empty status with nonzero count");

  // A refused append reports a full list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == blvr_pkg::ST_FULL) |->
      out_count == blvr_pkg::COUNT_W'(DEPTH))
    else $error("full status with wrong count");

  // A stalled result keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind bounded_list_with_value_removal blvr_chk #(.DEPTH(DEPTH)) u_blvr_chk (.*);
